### rtl/cidb32_pkg.sv
package cidb32_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 5;
  localparam int unsigned VALUE_W = 64;

  localparam logic [CHAR_W-1:0] CHAR_US    = 8'h5F;
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

  typedef enum logic [1:0] {
    CLS_NONASCII,
    CLS_UNDERSCORE,
    CLS_ALNUM,
    CLS_OTHER
  } char_cls_t;

  typedef struct packed {
    char_cls_t          cls;
    logic               body_ok;
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } item_t;

  typedef struct packed {
    logic               ok;
    logic [DIGIT_W-1:0] digit;
  } digit_t;

  function automatic digit_t b32_digit(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] lc;
    digit_t            d;
    lc = c;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      lc = c + CASE_DELTA;
    end
    d.ok    = 1'b1;
    d.digit = '0;
    if (lc >= CHAR_0 && lc <= CHAR_9) begin
      d.digit = DIGIT_W'(lc - CHAR_0);
    end else begin
      unique case (lc)
        8'h6F:   d.digit = 5'd0;
        8'h69:   d.digit = 5'd1;
        8'h6C:   d.digit = 5'd1;
        8'h61:   d.digit = 5'd10;
        8'h62:   d.digit = 5'd11;
        8'h63:   d.digit = 5'd12;
        8'h64:   d.digit = 5'd13;
        8'h65:   d.digit = 5'd14;
        8'h66:   d.digit = 5'd15;
        8'h67:   d.digit = 5'd16;
        8'h68:   d.digit = 5'd17;
        8'h6A:   d.digit = 5'd18;
        8'h6B:   d.digit = 5'd19;
        8'h6D:   d.digit = 5'd20;
        8'h6E:   d.digit = 5'd21;
        8'h70:   d.digit = 5'd22;
        8'h71:   d.digit = 5'd23;
        8'h72:   d.digit = 5'd24;
        8'h73:   d.digit = 5'd25;
        8'h74:   d.digit = 5'd26;
        8'h76:   d.digit = 5'd27;
        8'h77:   d.digit = 5'd28;
        8'h78:   d.digit = 5'd29;
        8'h79:   d.digit = 5'd30;
        8'h7A:   d.digit = 5'd31;
        default: d.ok    = 1'b0;
      endcase
    end
    return d;
  endfunction

endpackage

### rtl/cidb32_front.sv
module cidb32_front (
  input  logic [cidb32_pkg::CHAR_W-1:0] char_code,
  input  logic                          last_char,
  output cidb32_pkg::item_t             item
);

  cidb32_pkg::digit_t dig;

  always_comb begin
    dig          = cidb32_pkg::b32_digit(char_code);
    item.body_ok = dig.ok;
    item.digit   = dig.digit;
    item.last    = last_char;
    if (char_code[cidb32_pkg::CHAR_W-1]) begin
      item.cls = cidb32_pkg::CLS_NONASCII;
    end else if (char_code == cidb32_pkg::CHAR_US) begin
      item.cls = cidb32_pkg::CLS_UNDERSCORE;
    end else if ((char_code >= cidb32_pkg::CHAR_LO_A && char_code <= cidb32_pkg::CHAR_LO_Z) ||
                 (char_code >= cidb32_pkg::CHAR_0 && char_code <= cidb32_pkg::CHAR_9)) begin
      item.cls = cidb32_pkg::CLS_ALNUM;
    end else begin
      item.cls = cidb32_pkg::CLS_OTHER;
    end
  end

endmodule

### rtl/cidb32_queue.sv
module cidb32_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  cidb32_pkg::item_t wr_item,
  output logic              full,
  input  logic              rd_en,
  output logic              rd_valid,
  output cidb32_pkg::item_t rd_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cidb32_pkg::item_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full     = (count_r == CNT_FULL);
  assign rd_valid = (count_r != '0);
  assign rd_item  = entry_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL) else $error("queue count overflow");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (rd_ptr_r == wr_ptr_r)) else $error("empty queue with split pointers");

  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_FULL) |-> (rd_ptr_r == wr_ptr_r)) else $error("full queue with split pointers");

endmodule

### rtl/cidb32_back.sv
module cidb32_back #(
  parameter int unsigned BODY_CHARS = 13
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  cidb32_pkg::item_t              q_item,
  output logic                           q_pop,
  output logic                           empty,
  input  logic                           pop,
  output logic                           id_valid,
  output logic [cidb32_pkg::VALUE_W-1:0] order_value
);

  localparam int unsigned CNT_W = $clog2(BODY_CHARS + 2);
  localparam logic [CNT_W-1:0] CNT_BODY = CNT_W'(BODY_CHARS);
  localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(BODY_CHARS + 1);
  localparam int unsigned VW = cidb32_pkg::VALUE_W;
  localparam int unsigned DW = cidb32_pkg::DIGIT_W;

  logic             in_body_r, in_body_nxt;
  logic             prefix_r, prefix_nxt;
  logic             err_r, err_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0]    acc_r, acc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [VW-1:0]    out_value_r, out_value_nxt;
  logic             out_take, ok;

  assign out_take    = pop && out_valid_r;
  assign q_pop       = q_valid && (!q_item.last || !out_valid_r || out_take);
  assign empty       = !out_valid_r;
  assign id_valid    = out_ok_r;
  assign order_value = out_value_r;

  always_comb begin
    in_body_nxt = in_body_r;
    prefix_nxt  = prefix_r;
    err_nxt     = err_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    if (q_item.cls == cidb32_pkg::CLS_NONASCII) begin
      err_nxt = 1'b1;
    end else if (!in_body_r) begin
      unique case (q_item.cls)
        cidb32_pkg::CLS_UNDERSCORE: begin
          if (!prefix_r) begin
            err_nxt = 1'b1;
          end
          in_body_nxt = 1'b1;
        end
        cidb32_pkg::CLS_ALNUM: prefix_nxt = 1'b1;
        default:               err_nxt    = 1'b1;
      endcase
    end else begin
      if (!q_item.body_ok) begin
        err_nxt = 1'b1;
      end else begin
        acc_nxt = {acc_r[VW-DW-1:0], q_item.digit};
      end
      if (cnt_r < CNT_SAT) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    ok = !err_nxt && in_body_nxt && prefix_nxt && (cnt_nxt == CNT_BODY);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_value_nxt = out_value_r;
    if (q_pop && q_item.last) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = ok;
      out_value_nxt = ok ? acc_nxt : '0;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r   <= 1'b0;
      prefix_r    <= 1'b0;
      err_r       <= 1'b0;
      cnt_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop && q_item.last) begin
        in_body_r <= 1'b0;
        prefix_r  <= 1'b0;
        err_r     <= 1'b0;
        cnt_r     <= '0;
        acc_r     <= '0;
      end else if (q_pop) begin
        in_body_r <= in_body_nxt;
        prefix_r  <= prefix_nxt;
        err_r     <= err_nxt;
        cnt_r     <= cnt_nxt;
        acc_r     <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r    <= out_ok_nxt;
    out_value_r <= out_value_nxt;
  end

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_SAT) else $error("body count past saturation");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_value_r == '0)) else $error("invalid id with value");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(q_pop && q_item.last)) |->
      (!in_body_r && !prefix_r && !err_r && cnt_r == '0 && acc_r == '0))
    else $error("state not cleared after last item");

  a_body_needs_us: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> in_body_r) else $error("body count outside body");

endmodule

### rtl/compact_id_base32_decoder_unit.sv
// Path: items pass through the queue; a last item loads the result register.
// Throughput: one item per cycle; a last item waits only while an unread result holds
// the single result register, the four-entry queue absorbs the stall meanwhile.
// Reset: synchronous active-low rst_n empties the queue and the result register and
// clears the decode state; no clearing pass, items are taken the cycle after reset.
module compact_id_base32_decoder_unit #(
  parameter int unsigned BODY_CHARS  = 13,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [cidb32_pkg::CHAR_W-1:0]  in_char_code,
  input  logic                           in_last_char,
  output logic                           empty,
  input  logic                           pop,
  output logic                           out_id_valid,
  output logic [cidb32_pkg::VALUE_W-1:0] out_order_value
);

  cidb32_pkg::item_t fr_item;
  cidb32_pkg::item_t q_item;
  logic              q_valid;
  logic              q_pop;

  cidb32_front u_front (
    .char_code (in_char_code),
    .last_char (in_last_char),
    .item      (fr_item)
  );

  cidb32_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_item  (fr_item),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_item)
  );

  cidb32_back #(
    .BODY_CHARS (BODY_CHARS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .id_valid    (out_id_valid),
    .order_value (out_order_value)
  );

endmodule
